// ----- rtl/core/polygon_convexity_check_unit_assert.svh -----
// ----------------------------------------------------------------------------
// polygon convexity check unit assertion macros
// shared concurrent assertion forms, clocked on i_clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef POLYGON_CONVEXITY_CHECK_UNIT_ASSERT_SVH
`define POLYGON_CONVEXITY_CHECK_UNIT_ASSERT_SVH

// generic clocked assertion with reset disable
`define PCC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication on the unit clock and reset
`define PCC_ASSERT_IMPL(lbl, ante, cons, msg) \
    `PCC_ASSERT_CLK(lbl, i_clk, i_rst_n, (ante) |-> (cons), msg)

// next-cycle implication on the unit clock and reset
`define PCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    `PCC_ASSERT_CLK(lbl, i_clk, i_rst_n, (ante) |=> (cons), msg)

`endif

// ----- rtl/core/pcc_pkg.sv -----
// ----------------------------------------------------------------------------
// pcc_pkg
// types and constants shared by the polygon convexity check unit
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

    // coordinate and arithmetic widths
    localparam int COORD_WIDTH = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;

    // vertex counter
    localparam int                COUNT_WIDTH    = 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX      = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE      = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_TWO      = COUNT_WIDTH'(2);
    localparam logic [COUNT_WIDTH-1:0] TRIANGLE_COUNT = COUNT_WIDTH'(3);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic [COUNT_WIDTH-1:0]        t_count;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    // one vertex handed to the tracker
    typedef struct packed {
        logic   step;
        logic   last;
        t_point vertex;
    } t_step;

    // polygon verdict handed back to the top level
    typedef struct packed {
        logic   fire;
        logic   is_convex;
        t_count count;
    } t_verdict;

endpackage

`default_nettype wire

// ----- rtl/core/pcc_turn.sv -----
// ----------------------------------------------------------------------------
// pcc_turn
// exact sign test of the cross product for one vertex triple (o, m, n)
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_turn (
    input  pcc_pkg::t_point i_o,
    input  pcc_pkg::t_point i_m,
    input  pcc_pkg::t_point i_n,
    output logic            o_positive
);
    import pcc_pkg::*;

    logic signed [DIFF_WIDTH-1:0] x1, y1, x2, y2;
    logic signed [PROD_WIDTH-1:0] prod_a, prod_b;

    // edge vectors from the middle vertex, one bit wider so they stay exact
    assign x1 = DIFF_WIDTH'(i_n.x) - DIFF_WIDTH'(i_m.x);
    assign y1 = DIFF_WIDTH'(i_n.y) - DIFF_WIDTH'(i_m.y);
    assign x2 = DIFF_WIDTH'(i_o.x) - DIFF_WIDTH'(i_m.x);
    assign y2 = DIFF_WIDTH'(i_o.y) - DIFF_WIDTH'(i_m.y);

    // full-width products, then a signed compare gives the sign
    assign prod_a = PROD_WIDTH'(x1) * PROD_WIDTH'(y2);
    assign prod_b = PROD_WIDTH'(y1) * PROD_WIDTH'(x2);

    assign o_positive = prod_a > prod_b;

endmodule

`default_nettype wire

// ----- rtl/core/pcc_track.sv -----
// ----------------------------------------------------------------------------
// pcc_track
// per-polygon vertex history, turn sign tracking and closing verdict
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_track (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcc_pkg::t_step    i_step,
    output pcc_pkg::t_verdict o_verdict
);
    import pcc_pkg::*;

    t_point r_first, r_second, r_older, r_newer;
    t_point n_first, n_second, n_older, n_newer;
    t_count r_count, n_count;
    logic   r_turn_sign, n_turn_sign;
    logic   r_mixed, n_mixed;

    logic   pos_cur, pos_wrap_a, pos_wrap_b;
    t_count count_inc;
    logic   sign_upd, mixed_upd;

    // turn at the new vertex plus the two wrap-around turns
    pcc_turn u_turn_cur (
        .i_o        (r_older),
        .i_m        (r_newer),
        .i_n        (i_step.vertex),
        .o_positive (pos_cur)
    );

    pcc_turn u_turn_wrap_a (
        .i_o        (r_newer),
        .i_m        (i_step.vertex),
        .i_n        (r_first),
        .o_positive (pos_wrap_a)
    );

    pcc_turn u_turn_wrap_b (
        .i_o        (i_step.vertex),
        .i_m        (r_first),
        .i_n        (r_second),
        .o_positive (pos_wrap_b)
    );

    // running sign state after this vertex
    always_comb begin
        count_inc = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_ONE;
        sign_upd  = (r_count == COUNT_TWO) ? pos_cur : r_turn_sign;
        mixed_upd = r_mixed;
        if ((r_count > COUNT_TWO) && (pos_cur != r_turn_sign)) begin
            mixed_upd = 1'b1;
        end
    end

    // next state: shift history, clear control state on the closing vertex
    always_comb begin
        n_first     = r_first;
        n_second    = r_second;
        n_older     = r_older;
        n_newer     = r_newer;
        n_count     = r_count;
        n_turn_sign = r_turn_sign;
        n_mixed     = r_mixed;
        if (i_step.step) begin
            if (r_count == '0) begin
                n_first = i_step.vertex;
            end
            if (r_count == COUNT_ONE) begin
                n_second = i_step.vertex;
            end
            n_older = r_newer;
            n_newer = i_step.vertex;
            if (i_step.last) begin
                n_count     = '0;
                n_turn_sign = 1'b0;
                n_mixed     = 1'b0;
            end else begin
                n_count     = count_inc;
                n_turn_sign = sign_upd;
                n_mixed     = mixed_upd;
            end
        end
    end

    // verdict on the closing vertex
    always_comb begin
        o_verdict.fire  = i_step.step && i_step.last;
        o_verdict.count = count_inc;
        if (count_inc <= TRIANGLE_COUNT) begin
            o_verdict.is_convex = 1'b1;
        end else begin
            o_verdict.is_convex = !(mixed_upd || (pos_wrap_a != sign_upd)
                                    || (pos_wrap_b != sign_upd));
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_turn_sign <= 1'b0;
            r_mixed     <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_turn_sign <= n_turn_sign;
            r_mixed     <= n_mixed;
        end
    end

    // vertex history, always written before it is read
    always_ff @(posedge i_clk) begin
        r_first  <= n_first;
        r_second <= n_second;
        r_older  <= n_older;
        r_newer  <= n_newer;
    end

endmodule

`default_nettype wire

// ----- rtl/core/polygon_convexity_check_unit.sv -----
// ----------------------------------------------------------------------------
// polygon_convexity_check_unit
// streaming convexity test of a polygon by cross product signs
// ----------------------------------------------------------------------------
// Vertices stream in one word per cycle with a last-vertex flag, unless
// o_stall holds them; one result word (convex flag and saturating vertex
// count) leaves for each polygon through the vertex register and then the
// result register. The unit sustains one vertex per clock unless a closing
// vertex meets a full, stalled result register: a vertex register feeds
// three parallel cross-product sign units (current and both wrap-around
// turns) folded into the running sign state and, on the last vertex, into
// the result register, which lets later vertices in while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_convexity_check_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [pcc_pkg::COORD_WIDTH-1:0] i_vertex_x,
    input  logic signed [pcc_pkg::COORD_WIDTH-1:0] i_vertex_y,
    input  logic                                   i_last_vertex,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_is_convex,
    output logic [pcc_pkg::COUNT_WIDTH-1:0]        o_vertex_count
);
    import pcc_pkg::*;

    logic     r_in_valid;
    t_point   r_in_vertex;
    logic     r_in_last;
    logic     r_out_valid;
    logic     r_out_convex;
    t_count   r_out_count;

    logic     advance, accept_in;
    t_step    step;
    t_verdict verdict;

    // handshake: only a closing vertex needs the result slot to be free
    assign advance   = !r_in_last || !r_out_valid || !i_stall;
    assign o_stall   = r_in_valid && !advance;
    assign accept_in = i_valid && !o_stall;

    assign step.step   = r_in_valid && advance;
    assign step.last   = r_in_last;
    assign step.vertex = r_in_vertex;

    pcc_track u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .o_verdict (verdict)
    );

    // vertex register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept_in) begin
            r_in_valid <= 1'b1;
        end else if (step.step) begin
            r_in_valid <= 1'b0;
        end
    end

    // vertex register payload
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in_vertex.x <= i_vertex_x;
            r_in_vertex.y <= i_vertex_y;
            r_in_last     <= i_last_vertex;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (verdict.fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (verdict.fire) begin
            r_out_convex <= verdict.is_convex;
            r_out_count  <= verdict.count;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_is_convex    = r_out_convex;
    assign o_vertex_count = r_out_count;

endmodule

`default_nettype wire

// ----- rtl/core/pcc_checker.sv -----
// ----------------------------------------------------------------------------
// pcc_checker
// port-level checks of the polygon convexity check unit, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "polygon_convexity_check_unit_assert.svh"

module pcc_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_valid,
    input logic                                   o_stall,
    input logic signed [pcc_pkg::COORD_WIDTH-1:0] i_vertex_x,
    input logic signed [pcc_pkg::COORD_WIDTH-1:0] i_vertex_y,
    input logic                                   i_last_vertex,
    input logic                                   o_valid,
    input logic                                   i_stall,
    input logic                                   o_is_convex,
    input logic [pcc_pkg::COUNT_WIDTH-1:0]        o_vertex_count
);
    import pcc_pkg::*;

    logic                   out_waiting, in_waiting, small_poly;
    logic [COUNT_WIDTH:0]   out_word;
    logic [2*COORD_WIDTH:0] in_word;

    // words as seen on each side
    assign out_waiting = o_valid && i_stall;
    assign in_waiting  = i_valid && o_stall;
    assign out_word    = {o_is_convex, o_vertex_count};
    assign in_word     = {i_vertex_x, i_vertex_y, i_last_vertex};
    assign small_poly  = o_valid && (o_vertex_count <= TRIANGLE_COUNT);

    // a stalled result word holds
    `PCC_ASSERT_NEXT(a_out_hold, out_waiting, o_valid && $stable(out_word), "result moved")

    // a stalled vertex word holds
    `PCC_ASSERT_NEXT(a_in_hold, in_waiting, i_valid && $stable(in_word), "input word moved")

    // every polygon carries at least its closing word
    `PCC_ASSERT_IMPL(a_count_nonzero, o_valid, o_vertex_count != '0, "zero vertex count")

    // triangles and smaller always report convex
    `PCC_ASSERT_IMPL(a_small_convex, small_poly, o_is_convex, "small polygon not convex")

endmodule

bind polygon_convexity_check_unit pcc_checker u_pcc_checker (.*);

`default_nettype wire

// ----- tb/tb_polygon_convexity_check_unit.sv -----
// ----------------------------------------------------------------------------
// tb_polygon_convexity_check_unit
// self-checking bench for the streaming polygon convexity check
// ----------------------------------------------------------------------------
// Vertex words go in from a queue through a valid/stall driver with random
// gaps. A behavioral tracker follows every accepted vertex and predicts one
// verdict per polygon: convex flag and saturating vertex count. The monitor
// stalls the result side at random, once long enough to back up the input,
// and checks every result word against the oldest prediction. Stimulus runs
// from extreme-coordinate shapes to random convex, dented and scattered
// polygons.
// ----------------------------------------------------------------------------

module tb_polygon_convexity_check_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pcc_pkg::*;

    typedef struct {
        t_coord      x;
        t_coord      y;
        logic        last;
        int unsigned gap;
    } vertex_word_t;

    typedef struct {
        logic   convex;
        t_count count;
    } verdict_t;

    localparam int     RANDOM_VERTICES = 450;
    localparam int     PRESSURE_AFTER  = 14;
    localparam int     PRESSURE_CYCLES = 300;
    localparam t_coord COORD_LO        = t_coord'(-32768);
    localparam t_coord COORD_HI        = t_coord'(32767);

    // dut ports
    logic   i_clk         = 1'b0;
    logic   i_rst_n       = 1'b0;
    logic   i_valid       = 1'b0;
    t_coord i_vertex_x    = '0;
    t_coord i_vertex_y    = '0;
    logic   i_last_vertex = 1'b0;
    logic   i_stall       = 1'b0;
    logic   o_stall;
    logic   o_valid;
    logic   o_is_convex;
    t_count o_vertex_count;

    // stimulus and expectations
    vertex_word_t pending_vertices[$];
    verdict_t     verdict_q[$];

    // tracker state for the polygon in flight
    t_coord first_x  = '0, first_y  = '0;
    t_coord second_x = '0, second_y = '0;
    t_coord older_x  = '0, older_y  = '0;
    t_coord newer_x  = '0, newer_y  = '0;
    t_count seen_vertices = '0;
    bit     lead_turn     = 1'b0;
    bit     turn_mixed    = 1'b0;

    // driver and monitor bookkeeping
    vertex_word_t next_word, on_wire;
    bit           staged           = 1'b0;
    int unsigned  idle_left        = 0;
    int unsigned  hold_left        = 0;
    int unsigned  calm_left        = 0;
    bit           pressure_done    = 1'b0;
    int           mismatches       = 0;
    int           vertices_taken   = 0;
    int           polygons_closed  = 0;
    int           verdicts_checked = 0;
    int           input_held       = 0;

    polygon_convexity_check_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_last_vertex  (i_last_vertex),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_is_convex    (o_is_convex),
        .o_vertex_count (o_vertex_count)
    );

    always #4 i_clk = ~i_clk;

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // exact sign of the cross product at corner m, 17-bit differences
    function automatic bit turn_is_positive(input t_coord ox, input t_coord oy,
                                            input t_coord mx, input t_coord my,
                                            input t_coord nx, input t_coord ny);
        longint dx1, dy1, dx2, dy2;
        dx1 = longint'(nx) - longint'(mx);
        dy1 = longint'(ny) - longint'(my);
        dx2 = longint'(ox) - longint'(mx);
        dy2 = longint'(oy) - longint'(my);
        return (dx1 * dy2) > (dy1 * dx2);
    endfunction

    // follow one accepted vertex, predict the verdict on the last one
    task automatic track_vertex(input vertex_word_t w);
        t_count   prior;
        bit       pos;
        verdict_t v;
        prior = seen_vertices;
        if (prior == '0) begin
            first_x = w.x;
            first_y = w.y;
        end
        if (prior == COUNT_ONE) begin
            second_x = w.x;
            second_y = w.y;
        end
        if (prior >= COUNT_TWO) begin
            pos = turn_is_positive(older_x, older_y, newer_x, newer_y, w.x, w.y);
            if (prior == COUNT_TWO) lead_turn = pos;
            else if (pos != lead_turn) turn_mixed = 1'b1;
        end
        older_x = newer_x;
        older_y = newer_y;
        newer_x = w.x;
        newer_y = w.y;
        if (seen_vertices != COUNT_MAX) seen_vertices++;
        if (w.last) begin
            v.count = seen_vertices;
            if (seen_vertices <= TRIANGLE_COUNT) begin
                v.convex = 1'b1;
            end else begin
                // the two turns that wrap around to the first vertices
                if (turn_is_positive(older_x, older_y, newer_x, newer_y,
                                     first_x, first_y) != lead_turn)
                    turn_mixed = 1'b1;
                if (turn_is_positive(newer_x, newer_y, first_x, first_y,
                                     second_x, second_y) != lead_turn)
                    turn_mixed = 1'b1;
                v.convex = !turn_mixed;
            end
            verdict_q.push_back(v);
            polygons_closed++;
            first_x = '0;  first_y = '0;  second_x = '0; second_y = '0;
            older_x = '0;  older_y = '0;  newer_x = '0;  newer_y = '0;
            seen_vertices = '0;
            lead_turn = 1'b0;
            turn_mixed = 1'b0;
        end
    endtask

    // idle cycles ahead of a word: mostly none, some short, a few long
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    task automatic push_vertex(input t_coord x, input t_coord y, input logic last,
                               input int unsigned gap);
        vertex_word_t w;
        w.x = x;
        w.y = y;
        w.last = last;
        w.gap = gap;
        pending_vertices.push_back(w);
    endtask

    // points around a circle, either direction, optionally one pulled inward
    task automatic queue_ring(input int n, input bit dent, input bit calm);
        real cx, cy, rad, r, arc, phase;
        int  k, dent_at;
        cx = real'($urandom_range(0, 20000)) - 10000.0;
        cy = real'($urandom_range(0, 20000)) - 10000.0;
        rad = real'($urandom_range(40, 20000));
        arc = 6.283185307 / n;
        if ($urandom_range(0, 1) == 1) arc = -arc;
        phase = real'($urandom_range(0, 359)) * 0.0174533;
        dent_at = $urandom_range(0, n - 1);
        for (k = 0; k < n; k++) begin
            r = (dent && k == dent_at) ? rad * 0.2 : rad;
            push_vertex(t_coord'($rtoi(cx + r * $cos(phase + k * arc))),
                        t_coord'($rtoi(cy + r * $sin(phase + k * arc))),
                        k == n - 1, pick_gap(calm));
        end
    endtask

    // scattered points over the whole coordinate range
    task automatic queue_scatter(input int n, input bit calm);
        int k;
        for (k = 0; k < n; k++)
            push_vertex(t_coord'($urandom), t_coord'($urandom), k == n - 1,
                        pick_gap(calm));
    endtask

    // driver: presents queued words, holds them while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_stall) input_held++;
            if (i_valid && !o_stall) begin
                track_vertex(on_wire);
                vertices_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (!staged && pending_vertices.size() != 0) begin
                    next_word = pending_vertices.pop_front();
                    idle_left = next_word.gap;
                    staged = 1'b1;
                end
                if (staged && idle_left == 0) begin
                    i_valid       <= 1'b1;
                    i_vertex_x    <= next_word.x;
                    i_vertex_y    <= next_word.y;
                    i_last_vertex <= next_word.last;
                    on_wire = next_word;
                    staged = 1'b0;
                end else begin
                    i_valid <= 1'b0;
                    if (staged) idle_left--;
                end
            end
        end
    end

    // monitor: checks result words and drives the result-side stall
    always @(posedge i_clk) begin
        verdict_t want;
        int unsigned r;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("result word with no polygon closed",
                                    32'(o_vertex_count), 0);
                end else begin
                    want = verdict_q.pop_front();
                    if (o_is_convex !== want.convex)
                        report_mismatch("is_convex", 32'(o_is_convex),
                                        32'(want.convex));
                    if (o_vertex_count !== want.count)
                        report_mismatch("vertex_count", 32'(o_vertex_count),
                                        32'(want.count));
                    verdicts_checked++;
                end
            end
            // one long hold-off so the unit backs up into its input
            if (!pressure_done && verdicts_checked >= PRESSURE_AFTER) begin
                pressure_done = 1'b1;
                hold_left = PRESSURE_CYCLES;
                calm_left = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (calm_left > 0) begin
                calm_left--;
                i_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    calm_left = $urandom_range(20, 80);
                    i_stall <= 1'b0;
                end else if (r < 60) begin
                    i_stall <= 1'b0;
                end else if (r < 95) begin
                    hold_left = $urandom_range(0, 2);
                    i_stall <= 1'b1;
                end else begin
                    hold_left = $urandom_range(8, 30);
                    i_stall <= 1'b1;
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int queued, n, kind, k, wait_cycles;
        bit calm;

        // single vertex and two vertices at the coordinate extremes
        push_vertex(COORD_LO, COORD_HI, 1'b1, pick_gap(1'b0));
        push_vertex(COORD_HI, COORD_LO, 1'b0, pick_gap(1'b0));
        push_vertex(COORD_LO, COORD_HI, 1'b1, pick_gap(1'b0));
        // triangle, always convex
        push_vertex(16'sd0, 16'sd0, 1'b0, pick_gap(1'b0));
        push_vertex(COORD_HI, 16'sd0, 1'b0, pick_gap(1'b0));
        push_vertex(16'sd0, COORD_LO, 1'b1, pick_gap(1'b0));
        // full-range square, counterclockwise
        push_vertex(COORD_LO, COORD_LO, 1'b0, pick_gap(1'b0));
        push_vertex(COORD_HI, COORD_LO, 1'b0, pick_gap(1'b0));
        push_vertex(COORD_HI, COORD_HI, 1'b0, pick_gap(1'b0));
        push_vertex(COORD_LO, COORD_HI, 1'b1, pick_gap(1'b0));
        // dented quad
        push_vertex(16'sd0, 16'sd0, 1'b0, pick_gap(1'b0));
        push_vertex(16'sd10, 16'sd0, 1'b0, pick_gap(1'b0));
        push_vertex(16'sd2, 16'sd2, 1'b0, pick_gap(1'b0));
        push_vertex(16'sd0, 16'sd10, 1'b1, pick_gap(1'b0));
        // collinear points, every cross product zero
        push_vertex(16'sd0, 16'sd0, 1'b0, pick_gap(1'b0));
        push_vertex(16'sd1, 16'sd1, 1'b0, pick_gap(1'b0));
        push_vertex(16'sd2, 16'sd2, 1'b0, pick_gap(1'b0));
        push_vertex(16'sd3, 16'sd3, 1'b1, pick_gap(1'b0));
        // clockwise square
        push_vertex(16'sd0, 16'sd0, 1'b0, pick_gap(1'b0));
        push_vertex(16'sd0, 16'sd10, 1'b0, pick_gap(1'b0));
        push_vertex(16'sd10, 16'sd10, 1'b0, pick_gap(1'b0));
        push_vertex(16'sd10, 16'sd0, 1'b1, pick_gap(1'b0));

        // random polygons: mostly rings, some dented, some scattered
        queued = 0;
        while (queued < RANDOM_VERTICES) begin
            k = $urandom_range(0, 99);
            if (k < 8) n = $urandom_range(1, 3);
            else if (k < 95) n = $urandom_range(3, 12);
            else n = $urandom_range(20, 40);
            calm = ($urandom_range(0, 99) < 25);
            kind = $urandom_range(0, 99);
            if (kind < 50) queue_ring(n, 1'b0, calm);
            else if (kind < 70 && n >= 4) queue_ring(n, 1'b1, calm);
            else queue_scatter(n, calm);
            queued += n;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain the input side, then the expected verdicts
        do @(negedge i_clk);
        while (pending_vertices.size() != 0 || staged || i_valid);
        wait_cycles = 0;
        while (verdict_q.size() != 0 && wait_cycles < 2000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(negedge i_clk);
        if (verdict_q.size() != 0)
            report_mismatch("polygons with no result word", 0, verdict_q.size());

        $display("covered %0d vertices in %0d polygons, %0d results checked",
                 vertices_taken, polygons_closed, verdicts_checked);
        $display("vertex input held off %0d cycles under result back-pressure",
                 input_held);
        if (mismatches == 0)
            $display("tb_polygon_convexity_check_unit: clean");
        else
            $display("tb_polygon_convexity_check_unit: errors");
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("tb_polygon_convexity_check_unit: errors");
        $finish;
    end

endmodule
